/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is held.
`define PNN_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is held.
`define PNN_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pnn_pkg.sv */
// Shared constants, types and helpers for the Newell polygon normal unit.
// No dependencies.
package pnn_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int ACC_WIDTH_DEF   = 48;
  localparam int NORMAL_FRAC_DEF = 14;

  // Result component width.
  localparam int OUT_W  = 16;
  // The largest normalised magnitude lies in [2^(MAG_W-1), 2^MAG_W).
  localparam int MAG_W  = 24;
  localparam int ROOT_W = MAG_W + 1;
  localparam int SQ_W   = 2 * MAG_W + 2;

  // Root / divide unit modes.
  localparam logic RD_ROOT = 1'b0;
  localparam logic RD_DIV  = 1'b1;

  typedef struct packed {
    logic start;
    logic mode;
  } rd_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rd_stat_t;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

/* rtl/pnn_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on pnn_pkg for the default operand width.
module pnn_mul #(
  parameter int MW = pnn_pkg::ROOT_W
) (
  input  logic                   clk,
  input  logic signed [MW-1:0]   a,
  input  logic signed [MW-1:0]   b,
  output logic signed [2*MW-1:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

/* rtl/pnn_root_div.sv */
// Bit-serial unit: integer square root (two operand bits a step) or
// restoring division (one quotient bit a step), one shared subtractor.
// Depends on pnn_pkg.
module pnn_root_div #(
  parameter  int NORMAL_FRAC = pnn_pkg::NORMAL_FRAC_DEF,
  localparam int Q_W   = NORMAL_FRAC + 1,
  localparam int DIV_W = pnn_pkg::MAG_W + NORMAL_FRAC + 1,
  localparam int OPI_W = pnn_pkg::imax(pnn_pkg::SQ_W, DIV_W),
  localparam int RES_W = pnn_pkg::imax(pnn_pkg::ROOT_W, Q_W)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pnn_pkg::rd_ctrl_t             ctrl,
  input  logic [OPI_W-1:0]              opnd,
  input  logic [pnn_pkg::ROOT_W-1:0]    divisor,
  output pnn_pkg::rd_stat_t             stat,
  output logic [RES_W-1:0]              res
);

  localparam int OP_W  = pnn_pkg::imax(pnn_pkg::SQ_W, Q_W);
  localparam int RW    = pnn_pkg::ROOT_W + 3;
  localparam int CNT_W = $clog2(RES_W + 1);

  logic [RW-1:0]    rem_r;
  logic [OP_W-1:0]  sr_r;
  logic [RES_W-1:0] res_r;
  logic [CNT_W-1:0] cnt_r;
  logic             mode_r;
  logic             busy_r;
  logic             done_r;
  logic [RW-1:0]    cand;
  logic [RW-1:0]    dvs;
  logic [RW:0]      diff;
  logic             ge;
  logic             go;

  assign go = ctrl.start && !busy_r;

  always_comb begin
    if (mode_r == pnn_pkg::RD_ROOT) begin
      cand = {rem_r[RW-3:0], sr_r[OP_W-1 -: 2]};
      dvs  = RW'({res_r[pnn_pkg::ROOT_W-1:0], 2'b01});
    end else begin
      cand = {rem_r[RW-2:0], sr_r[OP_W-1]};
      dvs  = RW'(divisor);
    end
    diff = {1'b0, cand} - {1'b0, dvs};
    ge   = ~diff[RW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      mode_r <= pnn_pkg::RD_ROOT;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        mode_r <= ctrl.mode;
        busy_r <= 1'b1;
        cnt_r  <= (ctrl.mode == pnn_pkg::RD_DIV) ? CNT_W'(Q_W) : CNT_W'(pnn_pkg::ROOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_r <= '0;
      if (ctrl.mode == pnn_pkg::RD_DIV) begin
        rem_r <= RW'(opnd[DIV_W-1:Q_W]);
        sr_r  <= OP_W'(opnd[Q_W-1:0]) << (OP_W - Q_W);
      end else begin
        rem_r <= '0;
        sr_r  <= OP_W'(opnd[pnn_pkg::SQ_W-1:0]) << (OP_W - pnn_pkg::SQ_W);
      end
    end else if (busy_r) begin
      rem_r <= ge ? diff[RW-1:0] : cand;
      sr_r  <= (mode_r == pnn_pkg::RD_DIV) ? (sr_r << 1) : (sr_r << 2);
      res_r <= {res_r[RES_W-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign res       = res_r;

endmodule

/* rtl/polygon_normal_newell_unit.sv */
// Newell polygon normal: one vertex per input beat, unit normal on the last vertex.
// Vertex that opens a polygon: accepted only. Any other vertex: accepted, then 3 products
// through the one multiplier. Last vertex adds the closing edge, 0..ACC_WIDTH-24 one-bit
// normalising shifts, root and divisions (none for a zero sum), plus output back-pressure.
// rst_n is synchronous, active low: no polygon open, no result pending.
// Depends on pnn_pkg, pnn_mul, pnn_root_div.
module polygon_normal_newell_unit #(
  parameter int COORD_WIDTH = pnn_pkg::COORD_WIDTH_DEF,
  parameter int ACC_WIDTH   = pnn_pkg::ACC_WIDTH_DEF,
  parameter int NORMAL_FRAC = pnn_pkg::NORMAL_FRAC_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COORD_WIDTH-1:0]     in_coord_x,
  input  logic signed [COORD_WIDTH-1:0]     in_coord_y,
  input  logic signed [COORD_WIDTH-1:0]     in_coord_z,
  input  logic                              in_last_vertex,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [pnn_pkg::OUT_W-1:0]  out_normal_x,
  output logic signed [pnn_pkg::OUT_W-1:0]  out_normal_y,
  output logic signed [pnn_pkg::OUT_W-1:0]  out_normal_z,
  output logic                              out_degenerate
);

  // Multiplier is shared by the edge terms (coordinate differences and
  // sums) and by the squares of the normalised magnitudes.
  localparam int MW    = pnn_pkg::imax(COORD_WIDTH + 1, pnn_pkg::ROOT_W);
  localparam int PW    = 2 * MW;
  localparam int EW    = pnn_pkg::imax(PW, ACC_WIDTH);
  localparam int Q_W   = NORMAL_FRAC + 1;
  localparam int DIV_W = pnn_pkg::MAG_W + NORMAL_FRAC + 1;
  localparam int OPI_W = pnn_pkg::imax(pnn_pkg::SQ_W, DIV_W);
  localparam int RES_W = pnn_pkg::imax(pnn_pkg::ROOT_W, Q_W);
  localparam int EXT_W = pnn_pkg::imax(Q_W, pnn_pkg::OUT_W);
  localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << NORMAL_FRAC;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE  = 4'd0;  // waiting for a vertex beat
  localparam logic [3:0] ST_EDGE  = 4'd1;  // three terms of edge prev -> current
  localparam logic [3:0] ST_CLOSE = 4'd2;  // three terms of closing edge last -> first
  localparam logic [3:0] ST_DRAIN = 4'd3;  // last product lands in its sum
  localparam logic [3:0] ST_MAG   = 4'd4;  // sums to sign and magnitude, one a cycle
  localparam logic [3:0] ST_SHIFT = 4'd5;  // shift all three until max is in range
  localparam logic [3:0] ST_SQ    = 4'd6;  // squares into sq_r
  localparam logic [3:0] ST_SQW   = 4'd7;  // last square lands
  localparam logic [3:0] ST_ROOT  = 4'd8;  // length = isqrt(sum of squares)
  localparam logic [3:0] ST_DIV   = 4'd9;  // one rounded division per component
  localparam logic [3:0] ST_OUT   = 4'd10; // hand result to the output register

  logic [3:0] state_r;
  logic [1:0] cnt_r;
  logic       ph_r;      // 0: issue start to root/div unit, 1: wait for done
  logic       started_r; // a polygon is open
  logic       last_r;
  logic       deg_r;
  logic       acc_en_r;
  logic       acc_sq_r;
  logic [1:0] acc_sel_r;
  logic       out_valid_r;

  logic signed [COORD_WIDTH-1:0] first_r [3];
  logic signed [COORD_WIDTH-1:0] prev_r  [3];
  logic signed [COORD_WIDTH-1:0] cur_r   [3];
  logic signed [COORD_WIDTH-1:0] vin     [3];
  logic signed [COORD_WIDTH-1:0] eb      [3];
  logic [ACC_WIDTH-1:0]          sum_r   [3];
  logic [pnn_pkg::OUT_W-1:0]     comp_r  [3];
  logic [2:0]                    neg_r;
  logic [pnn_pkg::SQ_W-1:0]      sq_r;
  logic [pnn_pkg::ROOT_W-1:0]    len_r;

  logic signed [COORD_WIDTH-1:0] pa, pb, qa, qb;
  logic signed [COORD_WIDTH:0]   dif, smm;
  logic signed [MW-1:0]          mul_a, mul_b;
  logic signed [PW-1:0]          mul_p;
  logic signed [EW-1:0]          prod_ext;
  logic [pnn_pkg::MAG_W-1:0]     sel_mag;
  logic                          sel_neg;
  logic                          issue;
  logic                          any_hi, any_mid, all_zero;
  logic                          in_fire, out_load;

  logic [DIV_W-1:0]              div_num;
  logic [OPI_W-1:0]              rd_opnd;
  pnn_pkg::rd_ctrl_t             rd_ctrl;
  pnn_pkg::rd_stat_t             rd_stat;
  logic [RES_W-1:0]              rd_res;
  logic [Q_W-1:0]                q_raw, q_cl;
  logic [EXT_W-1:0]              q_ext;
  logic [pnn_pkg::OUT_W-1:0]     comp_val;

  assign vin[0] = in_coord_x;
  assign vin[1] = in_coord_y;
  assign vin[2] = in_coord_z;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  assign issue    = (state_r == ST_EDGE) || (state_r == ST_CLOSE) || (state_r == ST_SQ);

  // Edge operands. Term k pairs coordinate k+1 (difference) with k+2 (sum):
  // x: (a.y-b.y)(a.z+b.z), y: (a.z-b.z)(a.x+b.x), z: (a.x-b.x)(a.y+b.y).
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eb[i] = (state_r == ST_CLOSE) ? first_r[i] : cur_r[i];
    end
    case (cnt_r)
      2'd0: begin
        pa = prev_r[1]; pb = eb[1]; qa = prev_r[2]; qb = eb[2];
      end
      2'd1: begin
        pa = prev_r[2]; pb = eb[2]; qa = prev_r[0]; qb = eb[0];
      end
      default: begin
        pa = prev_r[0]; pb = eb[0]; qa = prev_r[1]; qb = eb[1];
      end
    endcase
    dif = (COORD_WIDTH+1)'(pa) - (COORD_WIDTH+1)'(pb);
    smm = (COORD_WIDTH+1)'(qa) + (COORD_WIDTH+1)'(qb);
  end

  // Component picked by cnt_r for squaring and dividing.
  always_comb begin
    sel_mag = '0;
    sel_neg = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (cnt_r == 2'(i)) begin
        sel_mag = sum_r[i][pnn_pkg::MAG_W-1:0];
        sel_neg = neg_r[i];
      end
    end
  end

  always_comb begin
    if (state_r == ST_SQ) begin
      mul_a = MW'(sel_mag);
      mul_b = MW'(sel_mag);
    end else begin
      mul_a = MW'(dif);
      mul_b = MW'(smm);
    end
  end

  pnn_mul #(.MW(MW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  // Product sign-extended (or wrapped) to the sum width.
  assign prod_ext = EW'(mul_p);

  // Range tests for the normalising shift, on all three magnitudes at once.
  always_comb begin
    any_hi   = 1'b0;
    any_mid  = 1'b0;
    all_zero = 1'b1;
    for (int i = 0; i < 3; i++) begin
      any_hi   = any_hi  | (|sum_r[i][ACC_WIDTH-1:pnn_pkg::MAG_W]);
      any_mid  = any_mid | (|sum_r[i][ACC_WIDTH-1:pnn_pkg::MAG_W-1]);
      all_zero = all_zero & ~(|sum_r[i]);
    end
  end

  // Root / divide unit: len = isqrt(sq), then (mag << F + len/2) / len.
  assign div_num = (DIV_W'(sel_mag) << NORMAL_FRAC) + DIV_W'(len_r >> 1);
  assign rd_opnd = (state_r == ST_DIV) ? OPI_W'(div_num) : OPI_W'(sq_r);
  assign rd_ctrl.start = !ph_r && !rd_stat.busy &&
                         ((state_r == ST_ROOT) || (state_r == ST_DIV));
  assign rd_ctrl.mode  = (state_r == ST_DIV) ? pnn_pkg::RD_DIV : pnn_pkg::RD_ROOT;

  pnn_root_div #(.NORMAL_FRAC(NORMAL_FRAC)) u_root_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (rd_ctrl),
    .opnd    (rd_opnd),
    .divisor (len_r),
    .stat    (rd_stat),
    .res     (rd_res)
  );

  // Quotient clamp to one, sign, then cut to the output field.
  always_comb begin
    q_raw = rd_res[Q_W-1:0];
    q_cl  = (q_raw > ONE_Q) ? ONE_Q : q_raw;
    q_ext = EXT_W'(q_cl);
    if (sel_neg) begin
      q_ext = '0 - q_ext;
    end
    comp_val = q_ext[pnn_pkg::OUT_W-1:0];
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ph_r        <= 1'b0;
      started_r   <= 1'b0;
      deg_r       <= 1'b0;
      acc_en_r    <= 1'b0;
      acc_sq_r    <= 1'b0;
      acc_sel_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_en_r  <= issue;
      acc_sq_r  <= (state_r == ST_SQ);
      acc_sel_r <= cnt_r;
      // a reload in ST_OUT keeps valid high on its own
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            cnt_r <= '0;
            if (!started_r) begin
              started_r <= 1'b1;
              if (in_last_vertex) begin
                state_r <= ST_CLOSE;
              end
            end else begin
              state_r <= ST_EDGE;
            end
          end
        end
        ST_EDGE: begin
          if (cnt_r == 2'd2) begin
            cnt_r   <= '0;
            state_r <= last_r ? ST_CLOSE : ST_IDLE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_CLOSE: begin
          if (cnt_r == 2'd2) begin
            cnt_r   <= '0;
            state_r <= ST_DRAIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_MAG;
        end
        ST_MAG: begin
          if (cnt_r == 2'd2) begin
            cnt_r   <= '0;
            state_r <= ST_SHIFT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_SHIFT: begin
          if (all_zero) begin
            deg_r   <= 1'b1;
            state_r <= ST_OUT;
          end else if (!any_hi && any_mid) begin
            state_r <= ST_SQ;
          end
        end
        ST_SQ: begin
          if (cnt_r == 2'd2) begin
            cnt_r   <= '0;
            state_r <= ST_SQW;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_SQW: begin
          ph_r    <= 1'b0;
          state_r <= ST_ROOT;
        end
        ST_ROOT: begin
          if (!ph_r) begin
            if (rd_ctrl.start) begin
              ph_r <= 1'b1;
            end
          end else if (rd_stat.done) begin
            ph_r    <= 1'b0;
            cnt_r   <= '0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (!ph_r) begin
            if (rd_ctrl.start) begin
              ph_r <= 1'b1;
            end
          end else if (rd_stat.done) begin
            ph_r <= 1'b0;
            if (cnt_r == 2'd2) begin
              cnt_r   <= '0;
              state_r <= ST_OUT;
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            started_r   <= 1'b0;
            deg_r       <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    // Product of the previous cycle lands in its sum.
    if (acc_en_r) begin
      if (acc_sq_r) begin
        sq_r <= sq_r + mul_p[pnn_pkg::SQ_W-1:0];
      end else begin
        for (int i = 0; i < 3; i++) begin
          if (acc_sel_r == 2'(i)) begin
            sum_r[i] <= sum_r[i] + prod_ext[ACC_WIDTH-1:0];
          end
        end
      end
    end
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          last_r <= in_last_vertex;
          for (int i = 0; i < 3; i++) begin
            if (!started_r) begin
              first_r[i] <= vin[i];
              prev_r[i]  <= vin[i];
              sum_r[i]   <= '0;
            end else begin
              cur_r[i] <= vin[i];
            end
          end
        end
      end
      ST_EDGE: begin
        if (cnt_r == 2'd2) begin
          for (int i = 0; i < 3; i++) begin
            prev_r[i] <= cur_r[i];
          end
        end
      end
      ST_MAG: begin
        for (int i = 0; i < 3; i++) begin
          if (cnt_r == 2'(i)) begin
            neg_r[i] <= sum_r[i][ACC_WIDTH-1];
            if (sum_r[i][ACC_WIDTH-1]) begin
              sum_r[i] <= '0 - sum_r[i];
            end
          end
        end
      end
      ST_SHIFT: begin
        if (all_zero) begin
          for (int i = 0; i < 3; i++) begin
            comp_r[i] <= '0;
          end
        end else if (any_hi) begin
          // right shift truncates, as a repeated halving would
          for (int i = 0; i < 3; i++) begin
            sum_r[i] <= sum_r[i] >> 1;
          end
        end else if (!any_mid) begin
          for (int i = 0; i < 3; i++) begin
            sum_r[i] <= sum_r[i] << 1;
          end
        end else begin
          sq_r <= '0;
        end
      end
      ST_ROOT: begin
        if (ph_r && rd_stat.done) begin
          len_r <= rd_res[pnn_pkg::ROOT_W-1:0];
        end
      end
      ST_DIV: begin
        if (ph_r && rd_stat.done) begin
          for (int i = 0; i < 3; i++) begin
            if (cnt_r == 2'(i)) begin
              comp_r[i] <= comp_val;
            end
          end
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_normal_x   <= comp_r[0];
          out_normal_y   <= comp_r[1];
          out_normal_z   <= comp_r[2];
          out_degenerate <= deg_r;
          for (int i = 0; i < 3; i++) begin
            sum_r[i] <= '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/pnn_checker.sv */
// Port-level checks for polygon_normal_newell_unit, attached by bind.
// Depends on assert_macros.svh and pnn_pkg.
`include "assert_macros.svh"

module pnn_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_last_vertex,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [pnn_pkg::OUT_W-1:0]  out_normal_x,
  input logic signed [pnn_pkg::OUT_W-1:0]  out_normal_y,
  input logic signed [pnn_pkg::OUT_W-1:0]  out_normal_z,
  input logic                              out_degenerate
);

  logic zero_vec;
  logic x_ok, y_ok, z_ok, in_range;
  logic last_beat;

  assign zero_vec  = (out_normal_x == '0) && (out_normal_y == '0) && (out_normal_z == '0);
  assign x_ok      = (out_normal_x >= -16'sd16384) && (out_normal_x <= 16'sd16384);
  assign y_ok      = (out_normal_y >= -16'sd16384) && (out_normal_y <= 16'sd16384);
  assign z_ok      = (out_normal_z >= -16'sd16384) && (out_normal_z <= 16'sd16384);
  assign in_range  = x_ok && y_ok && z_ok;
  assign last_beat = in_valid && in_ready && in_last_vertex;

  `PNN_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped while stalled")
  `PNN_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_normal_x) && $stable(out_degenerate), "stalled result changed")
  `PNN_ASSERT_IMP(a_deg_zero, out_valid && out_degenerate, zero_vec, "degenerate result with non-zero normal")
  `PNN_ASSERT_IMP(a_unit_range, out_valid && !out_degenerate, in_range, "normal component beyond one")
  `PNN_ASSERT_NXT(a_busy_after_last, last_beat, !in_ready, "input taken straight after a last vertex")

endmodule

bind polygon_normal_newell_unit pnn_checker u_pnn_checker (.*);

/* tb/polygon_normal_newell_unit_tb.sv */
// Self-checking bench for polygon_normal_newell_unit: random and directed polygons through
// valid/ready on both sides, each result checked against a Newell normal predictor.
// Depends on pnn_pkg and the unit's RTL only.
module polygon_normal_newell_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW          = pnn_pkg::COORD_WIDTH_DEF;
  localparam int AW          = pnn_pkg::ACC_WIDTH_DEF;
  localparam int NFRAC       = pnn_pkg::NORMAL_FRAC_DEF;
  localparam int OW          = pnn_pkg::OUT_W;
  // The largest normalised magnitude lands in [2^(NORM_TOP-1), 2^NORM_TOP).
  localparam int NORM_TOP    = 24;
  // Settling wait after each drain, well over what the worst closing vertex needs.
  localparam int DRAIN_CYCLES = 300;
  // Long receiver hold-off, and the watchdog limit on cycles with no beat at all.
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 4000;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 last;
  } vertex_t;

  typedef struct {
    logic signed [OW-1:0] nx;
    logic signed [OW-1:0] ny;
    logic signed [OW-1:0] nz;
    logic                 degen;
  } normal_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [CW-1:0] in_coord_x = '0;
  logic signed [CW-1:0] in_coord_y = '0;
  logic signed [CW-1:0] in_coord_z = '0;
  logic                 in_last_vertex = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [OW-1:0] out_normal_x;
  logic signed [OW-1:0] out_normal_y;
  logic signed [OW-1:0] out_normal_z;
  logic                 out_degenerate;

  polygon_normal_newell_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_coord_z     (in_coord_z),
    .in_last_vertex (in_last_vertex),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_normal_x   (out_normal_x),
    .out_normal_y   (out_normal_y),
    .out_normal_z   (out_normal_z),
    .out_degenerate (out_degenerate)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Vertices waiting to be offered, and normals the unit still owes us.
  vertex_t vertex_backlog[$];
  normal_t awaited_normals[$];

  // Idling odds in percent, set by the sequencer between phases (on falling edges).
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // Each bump of hold_asked starts one long receiver hold-off, counted down in hold_left from HOLD_CYCLES.
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;

  int mismatches = 0;
  int quiet_cycles = 0;

  // ---------------------------------------------------------------------------------------
  // Predictor state: open polygon, its first and previous vertex, and the three Newell sums.
  // ---------------------------------------------------------------------------------------
  logic signed [CW-1:0] first_x, first_y, first_z;
  logic signed [CW-1:0] prev_x, prev_y, prev_z;
  logic [AW-1:0]        sum_x, sum_y, sum_z;
  bit                   poly_open;

  // One Newell product (a1-b1)(a2+b2), kept to the accumulator width (wraps like the sums).
  function automatic logic [AW-1:0] newell_prod(input longint a1, input longint b1,
                                                input longint a2, input longint b2);
    longint p;
    p = (a1 - b1) * (a2 + b2);
    return p[AW-1:0];
  endfunction

  function automatic void accumulate_edge(
      input logic signed [CW-1:0] ax, input logic signed [CW-1:0] ay,
      input logic signed [CW-1:0] az, input logic signed [CW-1:0] bx,
      input logic signed [CW-1:0] by, input logic signed [CW-1:0] bz);
    sum_x = sum_x + newell_prod(ay, by, az, bz);
    sum_y = sum_y + newell_prod(az, bz, ax, bx);
    sum_z = sum_z + newell_prod(ax, bx, ay, by);
  endfunction

  // Two's complement sum split into sign and magnitude; the most negative sum gives 2^(AW-1).
  function automatic longint unsigned sum_magnitude(input logic [AW-1:0] s, output bit neg);
    logic [AW-1:0] t;
    neg = s[AW-1];
    t = ~s + 1'b1;
    return neg ? longint'(t) : longint'(s);
  endfunction

  // floor(sqrt(v)), one result bit at a time; v stays below 2^50 here.
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root, trial;
    int b;
    root = 0;
    for (b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // mag/len in Q1.NFRAC, rounded half up, capped at one, then signed and cut to the port.
  function automatic logic signed [OW-1:0] unit_part(input longint unsigned mag,
                                                     input longint unsigned len,
                                                     input bit neg);
    longint unsigned q;
    q = ((mag << NFRAC) + (len >> 1)) / len;
    if (q > (64'd1 << NFRAC)) q = 64'd1 << NFRAC;
    if (neg) q = 64'd0 - q;
    return q[OW-1:0];
  endfunction

  // Folds one accepted vertex into the open polygon; on the last vertex it closes the loop,
  // yields the unit normal and forgets the polygon.
  function automatic void fold_vertex(input vertex_t v, output bit emits, output normal_t res);
    longint unsigned mx, my, mz, top, len;
    bit nx, ny, nz;
    emits = 1'b0;
    res = '{default: '0};
    if (!poly_open) begin
      first_x = v.x;
      first_y = v.y;
      first_z = v.z;
      sum_x = '0;
      sum_y = '0;
      sum_z = '0;
      poly_open = 1'b1;
    end else begin
      accumulate_edge(prev_x, prev_y, prev_z, v.x, v.y, v.z);
    end
    prev_x = v.x;
    prev_y = v.y;
    prev_z = v.z;
    if (!v.last) return;

    // Closing edge back to the first vertex.
    accumulate_edge(prev_x, prev_y, prev_z, first_x, first_y, first_z);
    emits = 1'b1;
    mx = sum_magnitude(sum_x, nx);
    my = sum_magnitude(sum_y, ny);
    mz = sum_magnitude(sum_z, nz);
    top = mx;
    if (my > top) top = my;
    if (mz > top) top = mz;

    if (top == 0) begin
      // Zero-length sum: zero vector, flagged degenerate.
      res.degen = 1'b1;
    end else begin
      // Shift all three together until the largest sits just under 2^NORM_TOP.
      while ((top >> NORM_TOP) != 0) begin
        top = top >> 1; mx = mx >> 1; my = my >> 1; mz = mz >> 1;
      end
      while (top < (64'd1 << (NORM_TOP - 1))) begin
        top = top << 1; mx = mx << 1; my = my << 1; mz = mz << 1;
      end
      len = int_sqrt(mx * mx + my * my + mz * mz);
      res.nx = unit_part(mx, len, nx);
      res.ny = unit_part(my, len, ny);
      res.nz = unit_part(mz, len, nz);
    end

    first_x = '0; first_y = '0; first_z = '0;
    prev_x = '0; prev_y = '0; prev_z = '0;
    sum_x = '0; sum_y = '0; sum_z = '0;
    poly_open = 1'b0;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driver: offers the backlog one beat at a time; valid holds until the beat is taken.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : drive_vertices
    vertex_t nxt;
    if (!rst_n) begin
      in_valid       <= 1'b0;
      in_coord_x     <= '0;
      in_coord_y     <= '0;
      in_coord_z     <= '0;
      in_last_vertex <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (vertex_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = vertex_backlog.pop_front();
        in_valid       <= 1'b1;
        in_coord_x     <= nxt.x;
        in_coord_y     <= nxt.y;
        in_coord_z     <= nxt.z;
        in_last_vertex <= nxt.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus an occasional long hold-off on request.
  always @(posedge clk) begin : drive_ready
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_served != hold_asked) begin
      hold_served = hold_served + 1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: predicts from accepted vertex beats, then checks any result beat at the same
  // edge against the oldest normal still owed. Also runs the watchdog.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : watch_beats
    vertex_t seen;
    normal_t want;
    bit emits;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        seen.x = in_coord_x;
        seen.y = in_coord_y;
        seen.z = in_coord_z;
        seen.last = in_last_vertex;
        fold_vertex(seen, emits, want);
        if (emits) awaited_normals.push_back(want);
      end

      if (out_valid && out_ready) begin
        if (awaited_normals.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result: expected none, got %0d %0d %0d degenerate %0b",
                   $time, out_normal_x, out_normal_y, out_normal_z, out_degenerate);
        end else begin
          want = awaited_normals.pop_front();
          if (out_normal_x !== want.nx) begin
            mismatches++;
            $display("%0t normal_x: expected %0d, got %0d", $time, want.nx, out_normal_x);
          end
          if (out_normal_y !== want.ny) begin
            mismatches++;
            $display("%0t normal_y: expected %0d, got %0d", $time, want.ny, out_normal_y);
          end
          if (out_normal_z !== want.nz) begin
            mismatches++;
            $display("%0t normal_z: expected %0d, got %0d", $time, want.nz, out_normal_z);
          end
          if (out_degenerate !== want.degen) begin
            mismatches++;
            $display("%0t degenerate: expected %0b, got %0b", $time, want.degen,
                     out_degenerate);
          end
        end
      end

      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t watchdog: no beat for %0d cycles", $time, quiet_cycles);
          $display("polygon_normal_newell_unit: mismatch");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------------------
  task automatic push_vertex(input int x, input int y, input int z, input bit last);
    vertex_t v;
    v.x = x[CW-1:0];
    v.y = y[CW-1:0];
    v.z = z[CW-1:0];
    v.last = last;
    vertex_backlog.push_back(v);
  endtask

  // Coordinate flavours: full range, tiny (forces left shifts), mid range, rail to rail.
  function automatic int pick_coord(input int flavour);
    case (flavour)
      0: return int'($urandom_range(0, 65535)) - 32768;
      1: return int'($urandom_range(0, 16)) - 8;
      2: return int'($urandom_range(0, 1023)) - 512;
      default: return $urandom_range(0, 1) ? 32767 : -32768;
    endcase
  endfunction

  // One well-formed polygon with random content; now and then a collinear or repeated-point
  // one so that degenerate sums turn up alongside the single- and two-vertex cases.
  task automatic push_random_polygon();
    int n, flavour, i, bx, by, bz, dx, dy, dz;
    int shape;
    shape = $urandom_range(0, 99);
    if (shape < 12) n = $urandom_range(1, 2);
    else if (shape < 85) n = $urandom_range(3, 6);
    else n = $urandom_range(7, 12);
    flavour = $urandom_range(0, 3);
    if ($urandom_range(0, 9) == 0) begin
      // Points along a line, or one point repeated: zero area.
      bx = pick_coord(2); by = pick_coord(2); bz = pick_coord(2);
      dx = pick_coord(1); dy = pick_coord(1); dz = pick_coord(1);
      for (i = 0; i < n; i++) push_vertex(bx + i * dx, by + i * dy, bz + i * dz, i == n - 1);
    end else begin
      for (i = 0; i < n; i++)
        push_vertex(pick_coord(flavour), pick_coord(flavour), pick_coord(flavour), i == n - 1);
    end
  endtask

  // Sender pause: let every vertex go out and every owed normal come back, then settle.
  task automatic wait_drained();
    while (vertex_backlog.size() != 0 || in_valid) @(negedge clk);
    while (awaited_normals.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------------------
  // Sequencer. Apart from the reset release after a rising edge, its updates happen on falling edges.
  // ---------------------------------------------------------------------------------------
  initial begin : sequencer
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Phase one: sender rarely idles, receiver mostly stalls.
    send_idle_pct = 12;
    recv_idle_pct = 71;

    // Directed polygons.
    push_vertex(32767, -32768, 0, 1'b1);                 // single vertex: null closing edge
    push_vertex(-32768, 32767, -32768, 1'b0);            // two vertices: edges cancel
    push_vertex(32767, -32768, 32767, 1'b1);
    push_vertex(0, 0, 0, 1'b0);                          // unit triangle in xy, +z
    push_vertex(256, 0, 0, 1'b0);
    push_vertex(0, 256, 0, 1'b1);
    push_vertex(0, 256, 0, 1'b0);                        // same, wound the other way: -z
    push_vertex(256, 0, 0, 1'b0);
    push_vertex(0, 0, 0, 1'b1);
    push_vertex(-32768, -32768, -32768, 1'b0);           // rail-to-rail triangle
    push_vertex(32767, -32768, 32767, 1'b0);
    push_vertex(32767, 32767, -32768, 1'b1);
    push_vertex(0, 0, 0, 1'b0);                          // collinear: zero sum
    push_vertex(1, 1, 1, 1'b0);
    push_vertex(2, 2, 2, 1'b1);
    push_vertex(0, 0, 0, 1'b0);                          // smallest non-zero area
    push_vertex(1, 0, 0, 1'b0);
    push_vertex(0, 1, 0, 1'b1);
    push_vertex(256, 0, 0, 1'b0);                        // equal components
    push_vertex(0, 256, 0, 1'b0);
    push_vertex(0, 0, 256, 1'b1);
    push_vertex(-1, -1, -1, 1'b0);                       // all-ones and sign bits
    push_vertex(-32768, 0, 32767, 1'b1);

    while (vertex_backlog.size() < 400) push_random_polygon();

    // Long receiver hold-off while the sender still has plenty queued.
    while (vertex_backlog.size() > 200) @(negedge clk);
    hold_asked = hold_asked + 1;
    wait_drained();

    // Phase two: the other way round.
    send_idle_pct = 71;
    recv_idle_pct = 12;
    while (vertex_backlog.size() < 400) push_random_polygon();
    wait_drained();

    // Phase three: no idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (vertex_backlog.size() < 400) push_random_polygon();
    wait_drained();

    if (mismatches == 0 && awaited_normals.size() == 0) begin
      $display("polygon_normal_newell_unit: match");
    end else begin
      $display("polygon_normal_newell_unit: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/pnn_pkg.sv
rtl/pnn_mul.sv
rtl/pnn_root_div.sv
rtl/polygon_normal_newell_unit.sv
rtl/pnn_checker.sv
tb/polygon_normal_newell_unit_tb.sv
